// ===== design/mcic_pkg.sv =====
// Shared constants for the multi-CPU interrupt controller: operation codes,
// register map offsets, acknowledge codes and configuration register indexes.
// No dependencies.
package mcic_pkg;

	localparam int OP_W    = 2;
	localparam int CPU_W   = 3;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 32;
	localparam int IRQ_W   = 10;
	localparam int LINES_W = 8;
	localparam int CFGI_W  = 1;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_LEVEL = 2'd2;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

	localparam logic [CFGI_W-1:0] CFG_NUM_CPUS  = 1'b0;
	localparam logic [CFGI_W-1:0] CFG_NUM_WORDS = 1'b1;

	localparam logic [ADDR_W-1:0] A_REV      = 16'h0000;
	localparam logic [ADDR_W-1:0] A_CAPS     = 16'h0004;
	localparam logic [ADDR_W-1:0] A_SRST     = 16'h000C;
	localparam logic [ADDR_W-1:0] A_GSETUP   = 16'h0010;
	localparam logic [ADDR_W-1:0] A_WHOAMI   = 16'h2000;
	localparam logic [ADDR_W-1:0] A_ACK      = 16'h2004;
	localparam logic [ADDR_W-1:0] A_IPI_SET  = 16'h2008;
	localparam logic [ADDR_W-1:0] A_IPI_CLR  = 16'h200C;
	localparam logic [ADDR_W-1:0] A_IMSK_SET = 16'h2024;
	localparam logic [ADDR_W-1:0] A_IMSK_CLR = 16'h2028;
	localparam logic [ADDR_W-1:0] A_DEF_SET  = 16'h202C;
	localparam logic [ADDR_W-1:0] A_DEF_CLR  = 16'h2030;
	localparam logic [ADDR_W-1:0] A_TGT_LO   = 16'h3000;
	localparam logic [ADDR_W-1:0] A_TGT_HI   = 16'h4000;
	localparam logic [ADDR_W-1:0] A_PMW_LO   = 16'h4000;
	localparam logic [ADDR_W-1:0] A_PMW_HI   = 16'h4200;
	localparam logic [ADDR_W-1:0] A_PMR_LO   = 16'h4100;
	localparam logic [ADDR_W-1:0] A_PEND_RD  = 16'h4200;
	localparam logic [ADDR_W-1:0] A_PMR_HI   = 16'h4280;
	localparam logic [ADDR_W-1:0] A_ALIAS    = 16'h5000;

	localparam logic [1:0] PM_PEND_SET = 2'd0;
	localparam logic [1:0] PM_PEND_CLR = 2'd1;
	localparam logic [1:0] PM_MASK_SET = 2'd2;
	localparam logic [1:0] PM_MASK_CLR = 2'd3;

	localparam logic [DATA_W-1:0] REVISION = 32'd2;
	localparam logic [DATA_W-1:0] ACK_SELF = 32'h0004_0002;
	localparam logic [DATA_W-1:0] ACK_NORM = 32'h0004_0001;
	localparam logic [DATA_W-1:0] ACK_SRC  = 32'h0001_0000;
	localparam logic [DATA_W-1:0] SRC_NUM_MASK = 32'h0000_03FF;
	localparam logic [DATA_W-1:0] RD_BAD   = 32'hFFFF_FFFF;

endpackage

// ===== design/mcic_if.sv =====
// Channel interfaces of the interrupt controller: request, response and
// configuration write. Depends on mcic_pkg for field widths.
interface mcic_req_if;
	logic                           valid;
	logic                           ready;
	logic [mcic_pkg::OP_W-1:0]      op;
	logic [mcic_pkg::CPU_W-1:0]     cpu;
	logic [mcic_pkg::ADDR_W-1:0]    addr;
	logic [mcic_pkg::DATA_W-1:0]    wdata;
	logic [mcic_pkg::IRQ_W-1:0]     irq_num;
	logic                           level;
	modport source(output valid, op, cpu, addr, wdata, irq_num, level, input ready);
	modport sink(input valid, op, cpu, addr, wdata, irq_num, level, output ready);
endinterface

interface mcic_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mcic_pkg::DATA_W-1:0]    rdata;
	logic [mcic_pkg::LINES_W-1:0]   irq_lines;
	modport source(output valid, rdata, irq_lines, input ready);
	modport sink(input valid, rdata, irq_lines, output ready);
endinterface

interface mcic_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mcic_pkg::CFGI_W-1:0]    index;
	logic [mcic_pkg::DATA_W-1:0]    wdata;
	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// ===== design/mcic_tgt_ram.sv =====
// Source destination memory: one write port, one read port, registered read.
// No package dependencies.
module mcic_tgt_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/mcic_ffs.sv =====
// Lowest-set-bit finder shared by the acknowledge and tick source scans.
// No package dependencies.
module mcic_ffs (
	input  logic [31:0] vec,
	output logic [4:0]  idx
);
	always_comb begin
		idx = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (vec[i]) begin
				idx = 5'(i);
			end
		end
	end
endmodule

// ===== design/multi_cpu_interrupt_controller.sv =====
// Interrupt controller for up to MAX_CPUS CPUs and 32*MAX_SOURCE_WORDS sources.
// One request at a time: a register access, line level change or IPI acknowledge
// passes through S_EXEC (and S_RDT for a target read) to S_DONE, which waits while
// an earlier response is unaccepted, registers the response and returns to S_IDLE.
// Acknowledge of an external source and the tick walk the source words, one per
// cycle while a word holds no pending unmasked source; each such source passes
// through S_BIT and S_EVAL, since its destination is read from the registered
// read port of the target memory. After reset all 32*MAX_SOURCE_WORDS entries
// of the target memory are cleared, and a soft reset clears the first 32 times the
// effective word count of entries the same way, with no request taken meanwhile.
// Depends on mcic_pkg, mcic_if, mcic_tgt_ram and mcic_ffs.
module multi_cpu_interrupt_controller #(
	parameter int MAX_CPUS         = 8,
	parameter int MAX_SOURCE_WORDS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	mcic_req_if.sink   req,
	mcic_rsp_if.source rsp,
	mcic_cfg_if.sink   cfg
);
	localparam int CI     = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int WW     = (MAX_SOURCE_WORDS > 1) ? $clog2(MAX_SOURCE_WORDS) : 1;
	localparam int WCW    = $clog2(MAX_SOURCE_WORDS + 1);
	localparam int SRC_AW = WW + 5;
	localparam int NSRC   = MAX_SOURCE_WORDS * 32;
	localparam int CLRW   = SRC_AW + 1;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_RDT  = 3'd3;
	localparam logic [2:0] S_WORD = 3'd4;
	localparam logic [2:0] S_BIT  = 3'd5;
	localparam logic [2:0] S_EVAL = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q;

	logic [3:0] num_cpus_q;
	logic [5:0] num_words_q;

	logic [31:0] pend_q [MAX_SOURCE_WORDS];
	logic [31:0] mask_q [MAX_SOURCE_WORDS];
	logic [MAX_CPUS-1:0] ipi_pn_q [MAX_CPUS];
	logic [MAX_CPUS-1:0] ipi_dn_q [MAX_CPUS];
	logic [MAX_CPUS-1:0] ipi_ps_q, ipi_ds_q, ipi_mn_q, ipi_ms_q;
	logic [MAX_CPUS-1:0] line_q;
	logic [31:0] gsetup_q;

	logic [1:0]  op_q;
	logic [2:0]  cpu_q;
	logic [15:0] addr_q;
	logic [31:0] wdata_q;
	logic [9:0]  irq_q;
	logic        level_q;

	logic [WCW-1:0]    word_q;
	logic [31:0]       act_q;
	logic [4:0]        bit_q;
	logic              is_ack_q;
	logic [CI-1:0]     own_q;
	logic [MAX_CPUS:0] intr_q;
	logic [MAX_CPUS-1:0] pot_q;
	logic [CLRW-1:0]   clr_q, clr_end_q;
	logic              soft_q;
	logic [31:0]       res_q;
	logic              out_valid_q;
	logic [31:0]       out_rdata_q;
	logic [7:0]        out_lines_q;

	// effective configuration
	logic [31:0] n32, w32, nsrc32;
	always_comb begin
		n32 = 32'(num_cpus_q);
		if (n32 < 32'd1) n32 = 32'd1;
		if (n32 > 32'(MAX_CPUS)) n32 = 32'(MAX_CPUS);
		w32 = 32'(num_words_q);
		if (w32 < 32'd1) w32 = 32'd1;
		if (w32 > 32'(MAX_SOURCE_WORDS)) w32 = 32'(MAX_SOURCE_WORDS);
		nsrc32 = w32 << 5;
	end

	logic [MAX_CPUS-1:0] cmask;
	always_comb begin
		for (int k = 0; k < MAX_CPUS; k++) cmask[k] = 32'(k) < n32;
	end

	// address decode with alias window resolved
	logic [15:0] alias_off, ea;
	logic [31:0] eo32;
	logic        acc_ok, in_tgt, in_pmw, in_pmr, tgt_ok, pm_ok;
	logic [9:0]  tgt_idx;
	logic [4:0]  pm_idx;
	logic [CI-1:0] own_e;
	always_comb begin
		alias_off = addr_q - mcic_pkg::A_ALIAS;
		if (addr_q >= mcic_pkg::A_ALIAS) begin
			ea     = mcic_pkg::A_WHOAMI | {9'b0, addr_q[6:0]};
			eo32   = 32'(alias_off[15:7]);
			acc_ok = (32'(cpu_q) < n32) && (eo32 < n32);
		end else begin
			ea     = addr_q;
			eo32   = 32'(cpu_q);
			acc_ok = 32'(cpu_q) < n32;
		end
		own_e   = eo32[CI-1:0];
		in_tgt  = ea >= mcic_pkg::A_TGT_LO && ea < mcic_pkg::A_TGT_HI;
		in_pmw  = ea >= mcic_pkg::A_PMW_LO && ea < mcic_pkg::A_PMW_HI;
		in_pmr  = ea >= mcic_pkg::A_PMR_LO && ea < mcic_pkg::A_PMR_HI;
		tgt_idx = ea[11:2];
		pm_idx  = ea[6:2];
		tgt_ok  = 32'(tgt_idx) < nsrc32;
		pm_ok   = 32'(pm_idx) < w32;
	end

	logic [4:0] irq_w;
	logic       irq_ok;
	assign irq_w  = irq_q[9:5];
	assign irq_ok = 32'(irq_q) < nsrc32;

	// IPI view after folding deferred bits, and the IPI part of the tick
	logic [MAX_CPUS-1:0] pn_f [MAX_CPUS];
	logic [MAX_CPUS-1:0] ps_f;
	logic [MAX_CPUS:0]   intr_ipi;
	always_comb begin
		intr_ipi = '0;
		for (int i = 0; i < MAX_CPUS; i++) begin
			pn_f[i] = cmask[i] ? (ipi_pn_q[i] | ipi_dn_q[i]) : ipi_pn_q[i];
			ps_f[i] = cmask[i] ? (ipi_ps_q[i] | ipi_ds_q[i]) : ipi_ps_q[i];
			if (cmask[i]) begin
				intr_ipi[i] = (ps_f[i] && !ipi_ms_q[i])
					|| (!ipi_mn_q[i] && (|(pn_f[i] & cmask)));
			end
		end
	end

	// target memory and scan helpers
	logic [4:0]        ffs_idx;
	logic              mem_we;
	logic [SRC_AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]       mem_wdata, dest;

	mcic_ffs u_ffs (
		.vec(act_q),
		.idx(ffs_idx)
	);

	mcic_tgt_ram #(.DEPTH(NSRC), .AW(SRC_AW)) u_tgt (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(dest)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tgt_idx[SRC_AW-1:0];
		mem_wdata = wdata_q;
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q[SRC_AW-1:0];
			mem_wdata = '0;
		end else if (state_q == S_EXEC && op_q == mcic_pkg::OP_WRITE && acc_ok
				&& in_tgt && tgt_ok) begin
			mem_we = 1'b1;
		end
		if (state_q == S_BIT) mem_raddr = {word_q[WW-1:0], ffs_idx};
		else mem_raddr = tgt_idx[SRC_AW-1:0];
	end

	// tick spreading for one candidate source
	logic [MAX_CPUS:0] intr_nx;
	logic              dest_hit, found;
	always_comb begin
		intr_nx  = intr_q;
		dest_hit = |(intr_q & dest[MAX_CPUS:0]);
		found    = 1'b0;
		if (dest != 32'd0) begin
			if (!dest_hit) begin
				for (int k = 0; k < MAX_CPUS; k++) begin
					if (!found && cmask[k] && dest[k]) begin
						intr_nx[k] = 1'b1;
						found = 1'b1;
					end
				end
				// no configured CPU in the mask: bit n marks it busy
				for (int k = 0; k <= MAX_CPUS; k++) begin
					if (!found && 32'(k) == n32) intr_nx[k] = 1'b1;
				end
			end else begin
				for (int k = 0; k < MAX_CPUS; k++) begin
					if (!found && cmask[k] && !intr_q[k] && pot_q[k]) begin
						intr_nx[k] = 1'b1;
						found = 1'b1;
					end
				end
			end
		end
	end

	logic [SRC_AW-1:0] cand_idx;
	assign cand_idx = {word_q[WW-1:0], bit_q};

	assign req.ready = state_q == S_IDLE;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.rdata = out_rdata_q;
	assign rsp.irq_lines = out_lines_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			num_cpus_q  <= 4'd6;
			num_words_q <= 6'd18;
			for (int i = 0; i < MAX_SOURCE_WORDS; i++) begin
				pend_q[i] <= '0;
				mask_q[i] <= '1;
			end
			for (int i = 0; i < MAX_CPUS; i++) begin
				ipi_pn_q[i] <= '0;
				ipi_dn_q[i] <= '0;
			end
			ipi_ps_q    <= '0;
			ipi_ds_q    <= '0;
			ipi_mn_q    <= '1;
			ipi_ms_q    <= '1;
			line_q      <= '0;
			gsetup_q    <= '0;
			clr_q       <= '0;
			clr_end_q   <= CLRW'(NSRC);
			soft_q      <= 1'b0;
			out_valid_q <= 1'b0;
			word_q      <= '0;
			is_ack_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					mcic_pkg::CFG_NUM_CPUS:  num_cpus_q  <= cfg.wdata[3:0];
					mcic_pkg::CFG_NUM_WORDS: num_words_q <= cfg.wdata[5:0];
					default: ;
				endcase
			end
			if (rsp.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == clr_end_q - 1'b1) begin
						clr_q   <= '0;
						state_q <= soft_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.op;
						cpu_q   <= req.cpu;
						addr_q  <= req.addr;
						wdata_q <= req.wdata;
						irq_q   <= req.irq_num;
						level_q <= req.level;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_q   <= '0;
					state_q <= S_DONE;
					own_q   <= own_e;
					unique case (op_q)
						mcic_pkg::OP_WRITE: begin
							if (acc_ok && in_pmw && pm_ok) begin
								case (ea[8:7])
									mcic_pkg::PM_PEND_SET:
										pend_q[pm_idx[WW-1:0]] <= pend_q[pm_idx[WW-1:0]] | wdata_q;
									mcic_pkg::PM_PEND_CLR:
										pend_q[pm_idx[WW-1:0]] <= pend_q[pm_idx[WW-1:0]] & ~wdata_q;
									mcic_pkg::PM_MASK_SET:
										mask_q[pm_idx[WW-1:0]] <= mask_q[pm_idx[WW-1:0]] | wdata_q;
									default:
										mask_q[pm_idx[WW-1:0]] <= mask_q[pm_idx[WW-1:0]] & ~wdata_q;
								endcase
							end else if (acc_ok && !in_tgt && !in_pmw) begin
								unique case (ea)
									mcic_pkg::A_SRST: begin
										for (int i = 0; i < MAX_SOURCE_WORDS; i++) begin
											if (32'(i) < w32) mask_q[i] <= '1;
										end
										for (int i = 0; i < MAX_CPUS; i++) begin
											if (cmask[i]) begin
												ipi_pn_q[i] <= '0;
												ipi_dn_q[i] <= '0;
												ipi_ps_q[i] <= 1'b0;
												ipi_ds_q[i] <= 1'b0;
												ipi_mn_q[i] <= 1'b1;
												ipi_ms_q[i] <= 1'b1;
											end
										end
										clr_q     <= '0;
										clr_end_q <= CLRW'(nsrc32);
										soft_q    <= 1'b1;
										state_q   <= S_CLR;
									end
									mcic_pkg::A_GSETUP: gsetup_q <= wdata_q;
									mcic_pkg::A_IPI_SET: begin
										for (int i = 0; i < MAX_CPUS; i++) begin
											if (cmask[i] && wdata_q[i]) begin
												ipi_pn_q[i][own_e] <= 1'b1;
												if (!ipi_mn_q[i]) line_q[i] <= 1'b1;
											end
										end
										if (wdata_q[31]) begin
											ipi_ps_q[own_e] <= 1'b1;
											if (!ipi_ms_q[own_e]) line_q[own_e] <= 1'b1;
										end
									end
									mcic_pkg::A_IPI_CLR: begin
										for (int i = 0; i < MAX_CPUS; i++) begin
											if (cmask[i] && wdata_q[i]) ipi_pn_q[i][own_e] <= 1'b0;
										end
										if (wdata_q[31]) ipi_ps_q[own_e] <= 1'b0;
									end
									mcic_pkg::A_IMSK_SET: begin
										ipi_mn_q[own_e] <= ipi_mn_q[own_e] | wdata_q[0];
										ipi_ms_q[own_e] <= ipi_ms_q[own_e] | wdata_q[31];
									end
									mcic_pkg::A_IMSK_CLR: begin
										ipi_mn_q[own_e] <= ipi_mn_q[own_e] & ~wdata_q[0];
										ipi_ms_q[own_e] <= ipi_ms_q[own_e] & ~wdata_q[31];
									end
									mcic_pkg::A_DEF_SET: begin
										for (int i = 0; i < MAX_CPUS; i++) begin
											if (cmask[i] && wdata_q[i]) ipi_dn_q[i][own_e] <= 1'b1;
										end
										if (wdata_q[31]) ipi_ds_q[own_e] <= 1'b1;
									end
									mcic_pkg::A_DEF_CLR: begin
										for (int i = 0; i < MAX_CPUS; i++) begin
											if (cmask[i] && wdata_q[i]) ipi_dn_q[i][own_e] <= 1'b0;
										end
										if (wdata_q[31]) ipi_ds_q[own_e] <= 1'b0;
									end
									default: ;
								endcase
							end
						end
						mcic_pkg::OP_READ: begin
							res_q <= mcic_pkg::RD_BAD;
							if (!acc_ok) begin
								res_q <= mcic_pkg::RD_BAD;
							end else if (in_tgt) begin
								if (tgt_ok) state_q <= S_RDT;
							end else if (in_pmr) begin
								if (pm_ok) begin
									res_q <= (ea >= mcic_pkg::A_PEND_RD) ? pend_q[pm_idx[WW-1:0]]
										: mask_q[pm_idx[WW-1:0]];
								end
							end else begin
								unique case (ea)
									mcic_pkg::A_REV:    res_q <= mcic_pkg::REVISION;
									mcic_pkg::A_CAPS:   res_q <= ((n32 - 32'd1) << 16) | nsrc32;
									mcic_pkg::A_GSETUP: res_q <= gsetup_q;
									mcic_pkg::A_WHOAMI: res_q <= eo32;
									mcic_pkg::A_ACK: begin
										line_q[own_e] <= 1'b0;
										if (ipi_ps_q[own_e] && !ipi_ms_q[own_e]) begin
											ipi_ms_q[own_e] <= 1'b1;
											res_q <= mcic_pkg::ACK_SELF;
										end else if (!ipi_mn_q[own_e]
												&& (|(ipi_pn_q[own_e] & cmask))) begin
											ipi_mn_q[own_e] <= 1'b1;
											res_q <= mcic_pkg::ACK_NORM;
										end else begin
											res_q    <= '0;
											is_ack_q <= 1'b1;
											word_q   <= '0;
											state_q  <= S_WORD;
										end
									end
									default: ;
								endcase
							end
						end
						mcic_pkg::OP_LEVEL: begin
							if (irq_ok) begin
								pend_q[irq_w[WW-1:0]][irq_q[4:0]] <= level_q;
							end
						end
						default: begin
							for (int i = 0; i < MAX_CPUS; i++) begin
								ipi_pn_q[i] <= pn_f[i];
								if (cmask[i]) ipi_dn_q[i] <= '0;
							end
							ipi_ps_q <= ps_f;
							ipi_ds_q <= ipi_ds_q & ~cmask;
							intr_q   <= intr_ipi;
							pot_q    <= '0;
							is_ack_q <= 1'b0;
							word_q   <= '0;
							state_q  <= S_WORD;
						end
					endcase
				end
				S_RDT: begin
					res_q   <= dest;
					state_q <= S_DONE;
				end
				S_WORD: begin
					if (32'(word_q) >= w32) begin
						if (!is_ack_q) line_q <= line_q | (intr_q[MAX_CPUS-1:0] & cmask);
						res_q   <= '0;
						state_q <= S_DONE;
					end else if ((pend_q[word_q[WW-1:0]] & ~mask_q[word_q[WW-1:0]]) == '0) begin
						word_q <= word_q + 1'b1;
					end else begin
						act_q   <= pend_q[word_q[WW-1:0]] & ~mask_q[word_q[WW-1:0]];
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					bit_q   <= ffs_idx;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					act_q <= act_q & (act_q - 32'd1);
					if ((act_q & (act_q - 32'd1)) == '0) begin
						word_q  <= word_q + 1'b1;
						state_q <= S_WORD;
					end else begin
						state_q <= S_BIT;
					end
					if (is_ack_q) begin
						if (dest[5'(own_q)]) begin
							mask_q[word_q[WW-1:0]][bit_q] <= 1'b1;
							res_q   <= mcic_pkg::ACK_SRC | (32'(cand_idx) & mcic_pkg::SRC_NUM_MASK);
							state_q <= S_DONE;
						end
					end else begin
						intr_q <= intr_nx;
						if (dest != 32'd0 && !dest_hit) pot_q <= pot_q | dest[MAX_CPUS-1:0];
					end
				end
				default: begin
					// S_DONE: hand the result to the output register
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_rdata_q <= (op_q == mcic_pkg::OP_READ) ? res_q : '0;
						for (int i = 0; i < 8; i++) begin
							out_lines_q[i] <= (i < MAX_CPUS) ? line_q[i % MAX_CPUS] : 1'b0;
						end
						soft_q   <= 1'b0;
						is_ack_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
			endcase
		end
	end
endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for multi_cpu_interrupt_controller: directed tests, then
// randomized traffic under several CPU/source counts, checked against a predictor.
// Depends on mcic_pkg, mcic_if and the controller RTL.
module testbench;

	typedef struct packed {
		logic [mcic_pkg::DATA_W-1:0]  rdata;
		logic [mcic_pkg::LINES_W-1:0] lines;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #4 clk = ~clk;

	mcic_req_if req_ch();
	mcic_rsp_if rsp_ch();
	mcic_cfg_if cfg_ch();

	multi_cpu_interrupt_controller u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	// predicted controller state
	bit [31:0] src_pend[32];
	bit [31:0] src_mask[32];
	bit [31:0] src_tgt[1024];
	bit [31:0] ipi_pend[8];
	bit [31:0] ipi_def[8];
	bit [1:0]  ipi_msk[8];
	bit [7:0]  cpu_lines;
	bit [31:0] gsetup;
	bit [3:0]  cfg_cpus;
	bit [5:0]  cfg_words;

	rsp_t      pending_rsp[$];
	int        errors = 0;
	bit        calm = 1'b0;
	int        stall_left = 0;

	function automatic int ncpu();
		return (cfg_cpus < 1) ? 1 : (cfg_cpus > 8) ? 8 : cfg_cpus;
	endfunction

	function automatic int nwords();
		return (cfg_words < 1) ? 1 : (cfg_words > 32) ? 32 : cfg_words;
	endfunction

	function automatic void model_reset();
		for (int i = 0; i < 32; i++) begin
			src_pend[i] = '0;
			src_mask[i] = '1;
		end
		for (int i = 0; i < 1024; i++) src_tgt[i] = '0;
		for (int i = 0; i < 8; i++) begin
			ipi_pend[i] = '0;
			ipi_def[i] = '0;
			ipi_msk[i] = 2'b11;
		end
		cpu_lines = '0;
		gsetup = '0;
		cfg_cpus = 4'd6;
		cfg_words = 6'd18;
	endfunction

	function automatic void soft_clear();
		for (int i = 0; i < nwords(); i++) src_mask[i] = '1;
		for (int i = 0; i < nwords() * 32; i++) src_tgt[i] = '0;
		for (int i = 0; i < ncpu(); i++) begin
			ipi_msk[i] = 2'b11;
			ipi_pend[i] = '0;
			ipi_def[i] = '0;
		end
	endfunction

	function automatic void tick_update();
		int n;
		bit [31:0] intr, pot, dest;
		int f;
		n = ncpu();
		intr = '0;
		pot = '0;
		for (int i = 0; i < n; i++) begin
			ipi_pend[i] |= ipi_def[i];
			ipi_def[i] = '0;
		end
		for (int i = 0; i < n; i++) begin
			if (ipi_pend[i][31] && !ipi_msk[i][1]) intr[i] = 1'b1;
			if (!ipi_msk[i][0] && (ipi_pend[i] & ((32'd1 << n) - 1)) != 0) intr[i] = 1'b1;
		end
		for (int i = 0; i < nwords() * 32; i++) begin
			if (!src_pend[i >> 5][i & 31] || src_mask[i >> 5][i & 31]) continue;
			dest = src_tgt[i];
			if (dest == 0) continue;
			if ((intr & dest) == 0) begin
				f = n;
				for (int k = 0; k < n; k++)
					if (dest[k]) begin
						f = k;
						break;
					end
				intr[f] = 1'b1;
				pot |= dest;
			end else begin
				for (int k = 0; k < n; k++)
					if (!intr[k] && pot[k]) begin
						intr[k] = 1'b1;
						break;
					end
			end
		end
		for (int i = 0; i < n; i++) if (intr[i]) cpu_lines[i] = 1'b1;
	endfunction

	function automatic void reg_write(int o, bit [15:0] a, bit [31:0] v);
		int n, w, idx;
		n = ncpu();
		w = nwords();
		if (a >= mcic_pkg::A_ALIAS) begin
			idx = (a - mcic_pkg::A_ALIAS) >> 7;
			if (idx >= n) return;
			o = idx;
			a = mcic_pkg::A_WHOAMI + (a & 16'h7F);
		end
		if (a >= mcic_pkg::A_TGT_LO && a < mcic_pkg::A_TGT_HI) begin
			idx = (a - mcic_pkg::A_TGT_LO) >> 2;
			if (idx < w * 32) src_tgt[idx] = v;
			return;
		end
		if (a >= mcic_pkg::A_PMW_LO && a < mcic_pkg::A_PMW_HI) begin
			idx = ((a - mcic_pkg::A_PMW_LO) & 16'h7F) >> 2;
			if (idx >= w) return;
			case ((a - mcic_pkg::A_PMW_LO) >> 7)
				mcic_pkg::PM_PEND_SET: src_pend[idx] |= v;
				mcic_pkg::PM_PEND_CLR: src_pend[idx] &= ~v;
				mcic_pkg::PM_MASK_SET: src_mask[idx] |= v;
				default:               src_mask[idx] &= ~v;
			endcase
			return;
		end
		case (a)
			mcic_pkg::A_SRST:   soft_clear();
			mcic_pkg::A_GSETUP: gsetup = v;
			mcic_pkg::A_IPI_SET: begin
				for (int i = 0; i < n; i++)
					if (v[i]) begin
						ipi_pend[i][o] = 1'b1;
						if (!ipi_msk[i][0]) cpu_lines[i] = 1'b1;
					end
				if (v[31]) begin
					ipi_pend[o][31] = 1'b1;
					if (!ipi_msk[o][1]) cpu_lines[o] = 1'b1;
				end
			end
			mcic_pkg::A_IPI_CLR: begin
				for (int i = 0; i < n; i++) if (v[i]) ipi_pend[i][o] = 1'b0;
				if (v[31]) ipi_pend[o][31] = 1'b0;
			end
			mcic_pkg::A_IMSK_SET: ipi_msk[o] |= {v[31], v[0]};
			mcic_pkg::A_IMSK_CLR: ipi_msk[o] &= ~{v[31], v[0]};
			mcic_pkg::A_DEF_SET: begin
				for (int i = 0; i < n; i++) if (v[i]) ipi_def[i][o] = 1'b1;
				if (v[31]) ipi_def[o][31] = 1'b1;
			end
			mcic_pkg::A_DEF_CLR: begin
				for (int i = 0; i < n; i++) if (v[i]) ipi_def[i][o] = 1'b0;
				if (v[31]) ipi_def[o][31] = 1'b0;
			end
			default: ;
		endcase
	endfunction

	function automatic bit [31:0] take_ack(int o);
		cpu_lines[o] = 1'b0;
		if (ipi_pend[o][31] && !ipi_msk[o][1]) begin
			ipi_msk[o][1] = 1'b1;
			return mcic_pkg::ACK_SELF;
		end
		if (!ipi_msk[o][0] && (ipi_pend[o] & ((32'd1 << ncpu()) - 1)) != 0) begin
			ipi_msk[o][0] = 1'b1;
			return mcic_pkg::ACK_NORM;
		end
		for (int i = 0; i < nwords() * 32; i++)
			if (src_pend[i >> 5][i & 31] && !src_mask[i >> 5][i & 31] && src_tgt[i][o]) begin
				src_mask[i >> 5][i & 31] = 1'b1;
				return mcic_pkg::ACK_SRC | (i & mcic_pkg::SRC_NUM_MASK);
			end
		return '0;
	endfunction

	function automatic bit [31:0] reg_read(int o, bit [15:0] a);
		int n, w, idx;
		n = ncpu();
		w = nwords();
		if (a >= mcic_pkg::A_ALIAS) begin
			idx = (a - mcic_pkg::A_ALIAS) >> 7;
			if (idx >= n) return mcic_pkg::RD_BAD;
			o = idx;
			a = mcic_pkg::A_WHOAMI + (a & 16'h7F);
		end
		if (a >= mcic_pkg::A_TGT_LO && a < mcic_pkg::A_TGT_HI) begin
			idx = (a - mcic_pkg::A_TGT_LO) >> 2;
			return (idx < w * 32) ? src_tgt[idx] : mcic_pkg::RD_BAD;
		end
		if (a >= mcic_pkg::A_PMR_LO && a < mcic_pkg::A_PMR_HI) begin
			idx = ((a - mcic_pkg::A_PMW_LO) & 16'h7F) >> 2;
			if (idx >= w) return mcic_pkg::RD_BAD;
			return (a >= mcic_pkg::A_PEND_RD) ? src_pend[idx] : src_mask[idx];
		end
		case (a)
			mcic_pkg::A_REV:    return mcic_pkg::REVISION;
			mcic_pkg::A_CAPS:   return ((n - 1) << 16) | (w * 32);
			mcic_pkg::A_GSETUP: return gsetup;
			mcic_pkg::A_WHOAMI: return o;
			mcic_pkg::A_ACK:    return take_ack(o);
			default:            return mcic_pkg::RD_BAD;
		endcase
	endfunction

	function automatic rsp_t predict_rsp(bit [1:0] op, bit [2:0] cpu, bit [15:0] addr,
			bit [31:0] wdata, bit [9:0] irq, bit lvl);
		rsp_t r;
		r.rdata = '0;
		case (op)
			mcic_pkg::OP_WRITE: if (cpu < ncpu()) reg_write(cpu, addr, wdata);
			mcic_pkg::OP_READ:  r.rdata = (cpu < ncpu()) ? reg_read(cpu, addr) : mcic_pkg::RD_BAD;
			mcic_pkg::OP_LEVEL: if (irq < nwords() * 32) src_pend[irq >> 5][irq & 31] = lvl;
			default:            tick_update();
		endcase
		r.lines = cpu_lines;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	task automatic send_req(bit [1:0] op, bit [2:0] cpu, bit [15:0] addr,
			bit [31:0] wdata = 0, bit [9:0] irq = 0, bit lvl = 0);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.op = op;
		req_ch.cpu = cpu;
		req_ch.addr = addr;
		req_ch.wdata = wdata;
		req_ch.irq_num = irq;
		req_ch.level = lvl;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(predict_rsp(op, cpu, addr, wdata, irq, lvl));
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic write_cfg(logic [mcic_pkg::CFGI_W-1:0] index, bit [31:0] value);
		wait (pending_rsp.size() == 0);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = index;
		cfg_ch.wdata = value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (index == mcic_pkg::CFG_NUM_CPUS) cfg_cpus = value[3:0];
		else cfg_words = value[5:0];
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// response side: random stall bursts
	always @(negedge clk) begin
		if (calm) begin
			rsp_ch.ready = 1'b1;
		end else if (stall_left > 0) begin
			rsp_ch.ready = 1'b0;
			stall_left--;
		end else begin
			rsp_ch.ready = 1'b1;
			if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report("unexpected response", rsp_ch.rdata, 0);
			end else begin
				rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp_ch.rdata !== e.rdata) report("rdata", rsp_ch.rdata, e.rdata);
				if (rsp_ch.irq_lines !== e.lines) report("irq_lines", rsp_ch.irq_lines, e.lines);
			end
		end
	end

	task automatic test_identity();
		send_req(mcic_pkg::OP_READ, 0, mcic_pkg::A_REV);
		send_req(mcic_pkg::OP_READ, 5, mcic_pkg::A_CAPS);
		send_req(mcic_pkg::OP_READ, 3, mcic_pkg::A_WHOAMI);
		send_req(mcic_pkg::OP_WRITE, 1, mcic_pkg::A_GSETUP, 32'hFFFF_FFFF);
		send_req(mcic_pkg::OP_READ, 2, mcic_pkg::A_GSETUP);
		send_req(mcic_pkg::OP_READ, 7, mcic_pkg::A_REV);          // CPU beyond count
		send_req(mcic_pkg::OP_READ, 0, 16'h0008);                 // unmapped, time base
		send_req(mcic_pkg::OP_READ, 0, 16'h2006);                 // fixed register, low bits set
	endtask

	task automatic test_ipi();
		send_req(mcic_pkg::OP_WRITE, 2, mcic_pkg::A_IMSK_CLR, 32'h8000_0001);
		send_req(mcic_pkg::OP_WRITE, 0, mcic_pkg::A_IPI_SET, 32'h8000_003F);
		send_req(mcic_pkg::OP_WRITE, 2, mcic_pkg::A_IPI_SET, 32'h8000_0000);
		send_req(mcic_pkg::OP_READ, 2, mcic_pkg::A_ACK);
		send_req(mcic_pkg::OP_READ, 2, mcic_pkg::A_ACK);
		send_req(mcic_pkg::OP_WRITE, 1, mcic_pkg::A_DEF_SET, 32'h8000_0004);
		send_req(mcic_pkg::OP_TICK, 0, 0);
		send_req(mcic_pkg::OP_WRITE, 1, mcic_pkg::A_IPI_CLR, 32'h0000_0004);
		send_req(mcic_pkg::OP_WRITE, 3, mcic_pkg::A_DEF_CLR, 32'hFFFF_FFFF);
	endtask

	task automatic test_sources();
		send_req(mcic_pkg::OP_WRITE, 0, mcic_pkg::A_TGT_LO + 16'd4 * 575, 32'h0000_0006);
		send_req(mcic_pkg::OP_WRITE, 0, mcic_pkg::A_TGT_LO + 16'd4 * 576,
			32'h0000_0001); // out of range
		send_req(mcic_pkg::OP_WRITE, 0, mcic_pkg::A_PMW_LO + 16'h0180 + 16'd4 * 17,
			32'h8000_0000);
		send_req(mcic_pkg::OP_LEVEL, 0, 0, 0, 10'd575, 1'b1);
		send_req(mcic_pkg::OP_LEVEL, 0, 0, 0, 10'd1023, 1'b1);
		send_req(mcic_pkg::OP_TICK, 0, 0);
		send_req(mcic_pkg::OP_READ, 1, mcic_pkg::A_ACK);
		send_req(mcic_pkg::OP_READ, 4, mcic_pkg::A_PEND_RD + 16'd4 * 17 + 16'd3);
		send_req(mcic_pkg::OP_READ, 4, mcic_pkg::A_PMR_LO + 16'd4 * 31);
		send_req(mcic_pkg::OP_READ, 0, mcic_pkg::A_ALIAS + 16'h80 * 3 + 16'h0000);
		send_req(mcic_pkg::OP_READ, 0, mcic_pkg::A_ALIAS + 16'h80 * 6 + 16'h0004);
		send_req(mcic_pkg::OP_WRITE, 5, mcic_pkg::A_SRST, 0);
		send_req(mcic_pkg::OP_READ, 0, mcic_pkg::A_TGT_LO + 16'd4 * 575);
	endtask

	function automatic bit [15:0] pick_addr();
		bit [15:0] ipi_regs[8] = '{mcic_pkg::A_WHOAMI, mcic_pkg::A_ACK, mcic_pkg::A_IPI_SET,
			mcic_pkg::A_IPI_CLR, mcic_pkg::A_IMSK_SET, mcic_pkg::A_IMSK_CLR,
			mcic_pkg::A_DEF_SET, mcic_pkg::A_DEF_CLR};
		case ($urandom_range(0, 9))
			0: return ($urandom_range(0, 60) == 0) ? mcic_pkg::A_SRST :
				($urandom_range(0, 1) ? mcic_pkg::A_GSETUP :
				($urandom_range(0, 1) ? mcic_pkg::A_REV : mcic_pkg::A_CAPS));
			1, 2: return ipi_regs[$urandom_range(0, 7)];
			3: return mcic_pkg::A_TGT_LO + 4 * $urandom_range(0, 1023) + $urandom_range(0, 3);
			4, 5: return mcic_pkg::A_PMW_LO + 16'h80 * $urandom_range(0, 4)
				+ 4 * $urandom_range(0, 31) + $urandom_range(0, 3);
			6, 7: return mcic_pkg::A_ALIAS + 16'h80 * $urandom_range(0, 8)
				+ (ipi_regs[$urandom_range(0, 7)] & 16'h7F);
			8: return mcic_pkg::A_ACK;
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	task automatic random_item();
		bit [15:0] a;
		bit [31:0] d;
		bit [2:0] c;
		c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(0, ncpu() - 1);
		a = pick_addr();
		if ($urandom_range(0, 1)) d = $urandom();
		else d = $urandom() & 32'h8000_00FF;
		if (a >= mcic_pkg::A_PMW_LO + 16'h180 && a < mcic_pkg::A_PMW_HI)
			d = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: send_req(mcic_pkg::OP_WRITE, c, a, d);
			8, 9, 10, 11, 12, 13: send_req(mcic_pkg::OP_READ, c, a);
			14, 15, 16: send_req(mcic_pkg::OP_LEVEL, c, a, d, ($urandom_range(0, 7) == 0) ?
				$urandom_range(0, 1023) : $urandom_range(0, nwords() * 32 - 1),
				$urandom_range(0, 1));
			default: send_req(mcic_pkg::OP_TICK, c, a, d);
		endcase
	endtask

	// route one source to some CPUs, unmask and raise it, tick, and read the acknowledge register from a random CPU
	task automatic source_flow();
		int s;
		bit [2:0] c;
		s = $urandom_range(0, nwords() * 32 - 1);
		c = $urandom_range(0, ncpu() - 1);
		send_req(mcic_pkg::OP_WRITE, c, mcic_pkg::A_TGT_LO + 4 * s, $urandom_range(1, 255));
		send_req(mcic_pkg::OP_WRITE, c, mcic_pkg::A_PMW_LO + 16'h180 + 4 * (s >> 5),
			32'd1 << (s & 31));
		send_req(mcic_pkg::OP_LEVEL, c, 0, 0, s, 1'b1);
		send_req(mcic_pkg::OP_TICK, c, 0);
		send_req(mcic_pkg::OP_READ, $urandom_range(0, ncpu() - 1), mcic_pkg::A_ACK);
	endtask

	task automatic ipi_flow();
		bit [2:0] c;
		c = $urandom_range(0, ncpu() - 1);
		send_req(mcic_pkg::OP_WRITE, c, mcic_pkg::A_IMSK_CLR, $urandom() | 32'h8000_0001);
		send_req(mcic_pkg::OP_WRITE, $urandom_range(0, ncpu() - 1),
			$urandom_range(0, 1) ? mcic_pkg::A_IPI_SET : mcic_pkg::A_DEF_SET, $urandom());
		if ($urandom_range(0, 1)) send_req(mcic_pkg::OP_TICK, c, 0);
		send_req(mcic_pkg::OP_READ, c, mcic_pkg::A_ACK);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1: source_flow();
				2: ipi_flow();
				default: random_item();
			endcase
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.op = mcic_pkg::OP_WRITE;
		req_ch.cpu = '0;
		req_ch.addr = '0;
		req_ch.wdata = '0;
		req_ch.irq_num = '0;
		req_ch.level = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = mcic_pkg::CFG_NUM_CPUS;
		cfg_ch.wdata = '0;
		model_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_identity();
		test_ipi();
		test_sources();

		test_random(160);
		write_cfg(mcic_pkg::CFG_NUM_CPUS, 0);
		write_cfg(mcic_pkg::CFG_NUM_WORDS, 0);
		test_random(160);
		write_cfg(mcic_pkg::CFG_NUM_CPUS, 15);
		write_cfg(mcic_pkg::CFG_NUM_WORDS, 63);
		test_random(160);
		write_cfg(mcic_pkg::CFG_NUM_CPUS, 8);
		write_cfg(mcic_pkg::CFG_NUM_WORDS, 32);
		test_random(160);
		write_cfg(mcic_pkg::CFG_NUM_CPUS, 3);
		write_cfg(mcic_pkg::CFG_NUM_WORDS, 5);
		test_random(110);
		calm = 1'b1;
		test_random(90);

		wait (pending_rsp.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

	initial begin
		#200000000;
		$display("FAILURE");
		$finish;
	end
endmodule

// ===== sim.f =====
design/mcic_pkg.sv
design/mcic_if.sv
design/mcic_tgt_ram.sv
design/mcic_ffs.sv
design/multi_cpu_interrupt_controller.sv
bench/testbench.sv
